// ===== src/sid_pkg.sv =====
// ----------------------------------------------------------------------------
// Signed integer divider package
// Shared widths, constants and the record that travels down the cell chain.
// ----------------------------------------------------------------------------
package sid_pkg;

   // Operand and result width.
   localparam int DataWidth = 32;

   // One register stage on the way in, one cell per quotient bit, one stage out.
   localparam int Latency = DataWidth + 2;

   typedef logic [DataWidth-1:0] word_type;

   // Largest and smallest signed values of the word.
   localparam word_type MaxValue = {1'b0, {(DataWidth-1){1'b1}}};
   localparam word_type MinValue = {1'b1, {(DataWidth-1){1'b0}}};

   // Control flags that ride along with each transaction.
   typedef struct packed {
      logic valid;   // stage holds a live transaction
      logic neg;     // quotient gets a negative sign
      logic dz;      // divisor was zero
      logic pos_a;   // dividend was greater than zero
   } ctl_type;

   // Payload of one division step.
   typedef struct packed {
      word_type rem;   // partial remainder
      word_type num;   // dividend magnitude, next bit at the top
      word_type quo;   // quotient bits developed so far
      word_type den;   // divisor magnitude
   } data_type;

endpackage

// ===== src/sid_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring shift-and-subtract step, registered, handed to the next cell.
// ----------------------------------------------------------------------------
module sid_cell (
   input  logic              clock,
   input  logic              reset,
   input  sid_pkg::ctl_type  ctl_in_i,
   input  sid_pkg::data_type data_in_i,
   output sid_pkg::ctl_type  ctl_out_o,
   output sid_pkg::data_type data_out_o
);

   sid_pkg::ctl_type  ctl_ff;
   sid_pkg::ctl_type  ctl_in;
   sid_pkg::data_type data_ff;
   sid_pkg::data_type data_in;

   logic [sid_pkg::DataWidth:0]   shifted;
   logic [sid_pkg::DataWidth+1:0] diff;
   logic                          fits;

   // Bring down the next dividend bit and try to subtract the divisor.
   always_comb begin
      shifted = {data_in_i.rem, data_in_i.num[sid_pkg::DataWidth-1]};
      diff    = {1'b0, shifted} - {2'b00, data_in_i.den};
      fits    = ~diff[sid_pkg::DataWidth+1];
   end

   // Keep the difference when it fits, otherwise restore the shifted remainder.
   always_comb begin
      ctl_in       = ctl_in_i;
      data_in.den  = data_in_i.den;
      data_in.num  = {data_in_i.num[sid_pkg::DataWidth-2:0], 1'b0};
      data_in.quo  = {data_in_i.quo[sid_pkg::DataWidth-2:0], fits};
      data_in.rem  = fits ? diff[sid_pkg::DataWidth-1:0] : shifted[sid_pkg::DataWidth-1:0];
   end

   // Only the valid flag needs a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.neg   <= ctl_in.neg;
      ctl_ff.dz    <= ctl_in.dz;
      ctl_ff.pos_a <= ctl_in.pos_a;
      data_ff      <= data_in;
   end

   assign ctl_out_o  = ctl_ff;
   assign data_out_o = data_ff;

endmodule

// ===== src/sid_finish.sv =====
// ----------------------------------------------------------------------------
// Divider result stage
// Applies the sign, saturates the one overflow case and handles a zero divisor.
// ----------------------------------------------------------------------------
module sid_finish (
   input  logic                clock,
   input  logic                reset,
   input  sid_pkg::ctl_type    ctl_i,
   input  sid_pkg::word_type   quo_i,
   output logic                valid_o,
   output sid_pkg::word_type   quotient_o,
   output logic                saturated_o,
   output logic                divide_by_zero_o
);

   logic              valid_ff;
   logic              valid_in;
   sid_pkg::word_type quotient_ff;
   sid_pkg::word_type quotient_in;
   logic              saturated_ff;
   logic              saturated_in;
   logic              dz_ff;
   logic              dz_in;

   // Pick the final quotient and flags.
   always_comb begin
      valid_in     = ctl_i.valid;
      dz_in        = ctl_i.dz;
      saturated_in = 1'b0;
      if (ctl_i.dz) begin
         quotient_in = ctl_i.pos_a ? sid_pkg::MinValue : sid_pkg::MaxValue;
      end else if (ctl_i.neg) begin
         quotient_in = '0 - quo_i;
      end else if (quo_i[sid_pkg::DataWidth-1]) begin
         // Minimum divided by minus one does not fit.
         quotient_in  = sid_pkg::MaxValue;
         saturated_in = 1'b1;
      end else begin
         quotient_in = quo_i;
      end
   end

   // The strobe is control state; the payload is not reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quotient_ff  <= quotient_in;
      saturated_ff <= saturated_in;
      dz_ff        <= dz_in;
   end

   assign valid_o          = valid_ff;
   assign quotient_o       = quotient_ff;
   assign saturated_o      = saturated_ff;
   assign divide_by_zero_o = dz_ff;

endmodule

// ===== src/signed_integer_divider.sv =====
// ----------------------------------------------------------------------------
// Signed integer divider
// Pipelined restoring divider for signed 32-bit operands, quotient truncated
// toward zero.
// ----------------------------------------------------------------------------
// The divider takes one transaction on every clock cycle: busy stays low, so a
// start is always taken. Each result appears on the rsp_ ports with rsp_valid
// high for exactly one cycle, in the order the transactions came in. Each
// transaction passes through one register stage in front that takes the
// operand magnitudes, then the chain of 32 cells, one per quotient bit, then
// one register stage behind that applies the sign. A zero divisor raises
// rsp_divide_by_zero and returns the minimum when the dividend is positive and
// the maximum otherwise; minimum divided by minus one returns the maximum with
// rsp_saturated high.
// ----------------------------------------------------------------------------
module signed_integer_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [sid_pkg::DataWidth-1:0] req_dividend,
   input  logic signed [sid_pkg::DataWidth-1:0] req_divisor,
   output logic                                rsp_valid,
   output logic signed [sid_pkg::DataWidth-1:0] rsp_quotient,
   output logic                                rsp_saturated,
   output logic                                rsp_divide_by_zero
);

   sid_pkg::ctl_type  ctl_ff;
   sid_pkg::ctl_type  ctl_in;
   sid_pkg::data_type data_ff;
   sid_pkg::data_type data_in;

   sid_pkg::ctl_type  chain_ctl  [0:sid_pkg::DataWidth];
   sid_pkg::data_type chain_data [0:sid_pkg::DataWidth];

   sid_pkg::word_type a;
   sid_pkg::word_type b;
   logic              pos_a;
   logic              pos_b;

   sid_pkg::word_type quotient;

   // The chain never stalls, so a new transaction is always welcome.
   assign busy = 1'b0;

   // Operand magnitudes and sign bookkeeping.
   always_comb begin
      a     = sid_pkg::word_type'(req_dividend);
      b     = sid_pkg::word_type'(req_divisor);
      pos_a = (a != '0) && !a[sid_pkg::DataWidth-1];
      pos_b = (b != '0) && !b[sid_pkg::DataWidth-1];

      ctl_in.valid = start & ~busy;
      ctl_in.neg   = pos_a ^ pos_b;
      ctl_in.dz    = (b == '0);
      ctl_in.pos_a = pos_a;

      data_in.rem = '0;
      data_in.quo = '0;
      data_in.num = a[sid_pkg::DataWidth-1] ? ('0 - a) : a;
      data_in.den = b[sid_pkg::DataWidth-1] ? ('0 - b) : b;
   end

   // Input register stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.neg   <= ctl_in.neg;
      ctl_ff.dz    <= ctl_in.dz;
      ctl_ff.pos_a <= ctl_in.pos_a;
      data_ff      <= data_in;
   end

   assign chain_ctl[0]  = ctl_ff;
   assign chain_data[0] = data_ff;

   // One cell per quotient bit, most significant first.
   for (genvar k = 0; k < sid_pkg::DataWidth; k++) begin : g_cell
      sid_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl_in_i   (chain_ctl[k]),
         .data_in_i  (chain_data[k]),
         .ctl_out_o  (chain_ctl[k+1]),
         .data_out_o (chain_data[k+1])
      );
   end

   // Sign, saturation and zero-divisor handling.
   sid_finish u_finish (
      .clock            (clock),
      .reset            (reset),
      .ctl_i            (chain_ctl[sid_pkg::DataWidth]),
      .quo_i            (chain_data[sid_pkg::DataWidth].quo),
      .valid_o          (rsp_valid),
      .quotient_o       (quotient),
      .saturated_o      (rsp_saturated),
      .divide_by_zero_o (rsp_divide_by_zero)
   );

   assign rsp_quotient = quotient;

   // Every accepted transaction comes out after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(sid_pkg::Latency) rsp_valid)
      else $error("result missing after pipeline latency");

   // A result is never both clamped and from a zero divisor.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_saturated && rsp_divide_by_zero))
      else $error("saturated and divide_by_zero both set");

   // A clamped result is the maximum value.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (quotient == sid_pkg::MaxValue))
      else $error("saturated result is not the maximum");

   // A zero divisor gives one of the two extreme values.
   a_dz_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |->
         (quotient == sid_pkg::MaxValue || quotient == sid_pkg::MinValue))
      else $error("zero divisor result is not an extreme value");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Signed integer divider testbench
// Drives operand pairs into the pipelined divider with random gaps between
// starts and checks every quotient and flag against a typed or predicted value.
// A directed table covers the extremes and both error cases first, then a long
// random run mixes full-range, small, shifted and special operands.
// ----------------------------------------------------------------------------
module tb;

   // Typed values for the rows of the directed table.
   localparam sid_pkg::word_type Zero     = '0;
   localparam sid_pkg::word_type One      = sid_pkg::word_type'(1);
   localparam sid_pkg::word_type NegOne   = '1;
   localparam sid_pkg::word_type MaxValue = sid_pkg::MaxValue;
   localparam sid_pkg::word_type MinValue = sid_pkg::MinValue;

   // How a directed row is checked.
   localparam logic CheckTyped = 1'b1;
   localparam logic CheckModel = 1'b0;

   localparam int RandomItems   = 1600;
   localparam int DrainInterval = 500;
   localparam int WatchdogLimit = 2000;

   // One result transaction as the divider reports it.
   typedef struct packed {
      sid_pkg::word_type quotient;
      logic              saturated;
      logic              divide_by_zero;
   } div_result_type;

   localparam div_result_type NoResult = '0;

   // One row of the directed table.
   typedef struct packed {
      sid_pkg::word_type dividend;
      sid_pkg::word_type divisor;
      logic              check;
      div_result_type    want;
   } stim_row_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic signed [sid_pkg::DataWidth-1:0] req_dividend;
   logic signed [sid_pkg::DataWidth-1:0] req_divisor;
   logic                                rsp_valid;
   logic signed [sid_pkg::DataWidth-1:0] rsp_quotient;
   logic                                rsp_saturated;
   logic                                rsp_divide_by_zero;

   // Typed expectation that travels with the transaction on the request ports.
   logic               row_typed;
   div_result_type     row_want;

   div_result_type     expected_quotients[$];
   int                 error_count;
   int                 sent_count;
   int                 checked_count;
   int                 zero_count;
   int                 sat_count;
   int                 idle_cycles;

   signed_integer_divider i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .rsp_valid          (rsp_valid),
      .rsp_quotient       (rsp_quotient),
      .rsp_saturated      (rsp_saturated),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Zero-divisor rule, else restoring division on the magnitudes, then sign and saturation.
   function automatic div_result_type predict_quotient(sid_pkg::word_type dividend,
                                                       sid_pkg::word_type divisor);
      div_result_type              r;
      sid_pkg::word_type           mag_n;
      sid_pkg::word_type           mag_d;
      sid_pkg::word_type           quo;
      logic [sid_pkg::DataWidth:0] rem;
      logic                        pos_n;
      logic                        pos_d;
      r     = NoResult;
      pos_n = (dividend != Zero) && !dividend[sid_pkg::DataWidth-1];
      pos_d = (divisor != Zero) && !divisor[sid_pkg::DataWidth-1];
      if (divisor == Zero) begin
         r.divide_by_zero = 1'b1;
         r.quotient       = pos_n ? MinValue : MaxValue;
         return r;
      end
      mag_n = dividend[sid_pkg::DataWidth-1] ? -dividend : dividend;
      mag_d = divisor[sid_pkg::DataWidth-1] ? -divisor : divisor;
      rem   = '0;
      quo   = '0;
      for (int i = sid_pkg::DataWidth - 1; i >= 0; i--) begin
         rem = {rem[sid_pkg::DataWidth-1:0], mag_n[i]};
         if (rem >= {1'b0, mag_d}) begin
            rem    = rem - {1'b0, mag_d};
            quo[i] = 1'b1;
         end
      end
      if (pos_n != pos_d) begin
         r.quotient = -quo;
      end else if (quo > MaxValue) begin
         r.quotient  = MaxValue;
         r.saturated = 1'b1;
      end else begin
         r.quotient = quo;
      end
      return r;
   endfunction

   // Operand mix: full range, shifted, small, special values and powers of two.
   function automatic sid_pkg::word_type pick_operand();
      sid_pkg::word_type v;
      int                k;
      v = $urandom;
      k = $urandom_range(0, sid_pkg::DataWidth - 1);
      case ($urandom_range(0, 9))
         3, 4: v = sid_pkg::word_type'($signed(v) >>> k);
         5: v = sid_pkg::word_type'(int'($urandom_range(0, 200)) - 100);
         6: begin
            case ($urandom_range(0, 5))
               0: v = Zero;
               1: v = One;
               2: v = NegOne;
               3: v = MaxValue;
               4: v = MinValue;
               default: v = MinValue + One;
            endcase
         end
         7: begin
            v = One << k;
            if ($urandom_range(0, 1) == 1) v = -v;
         end
         8: v = (One << k) + sid_pkg::word_type'($urandom_range(0, 2)) - One;
         default: ;
      endcase
      return v;
   endfunction

   // Gap before a start: mostly none, some short, a few long.
   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Present one transaction after a gap and hold it until it is taken.
   task automatic send_division(sid_pkg::word_type dividend, sid_pkg::word_type divisor,
                                logic typed, div_result_type want, int gap);
      repeat (gap) begin
         @(negedge clock);
         start        <= 1'b0;
         req_dividend <= $urandom;
         req_divisor  <= $urandom;
         row_typed    <= 1'b0;
      end
      @(negedge clock);
      start        <= 1'b1;
      req_dividend <= dividend;
      req_divisor  <= divisor;
      row_typed    <= typed;
      row_want     <= want;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      sent_count++;
   endtask

   // Hold off new transactions until every pending quotient has come back.
   task automatic drain_pipeline();
      @(negedge clock);
      start <= 1'b0;
      while (expected_quotients.size() != 0) @(posedge clock);
   endtask

   // Compare each result with the oldest expectation, then record new starts.
   always @(posedge clock) begin
      div_result_type want;
      if (!reset) begin
         if (rsp_valid !== 1'b0) begin
            if (expected_quotients.size() == 0) begin
               $error("result with no transaction pending: quotient %h", rsp_quotient);
               error_count++;
            end else begin
               want = expected_quotients.pop_front();
               checked_count++;
               if (want.divide_by_zero) zero_count++;
               if (want.saturated) sat_count++;
               if (rsp_quotient !== want.quotient) begin
                  $error("quotient mismatch: expected %h, actual %h",
                         want.quotient, rsp_quotient);
                  error_count++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated mismatch: expected %b, actual %b",
                         want.saturated, rsp_saturated);
                  error_count++;
               end
               if (rsp_divide_by_zero !== want.divide_by_zero) begin
                  $error("divide_by_zero mismatch: expected %b, actual %b",
                         want.divide_by_zero, rsp_divide_by_zero);
                  error_count++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            if (row_typed) expected_quotients.push_back(row_want);
            else expected_quotients.push_back(predict_quotient(req_dividend, req_divisor));
         end
      end
   end

   // Watchdog: end the run when nothing has been accepted or returned for too long.
   always @(posedge clock) begin
      if (reset || (start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("Watchdog expired with %0d results pending.", expected_quotients.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      stim_row_type      directed_rows[23];
      sid_pkg::word_type a;
      sid_pkg::word_type b;
      bit                quiet;

      reset         = 1'b1;
      start         = 1'b0;
      req_dividend  = '0;
      req_divisor   = '0;
      row_typed     = 1'b0;
      row_want      = NoResult;
      error_count   = 0;
      sent_count    = 0;
      checked_count = 0;
      zero_count    = 0;
      sat_count     = 0;
      idle_cycles   = 0;

      directed_rows = '{
         // Overflow of the minimum by minus one, then every zero-divisor branch.
         '{MinValue, NegOne,   CheckTyped, '{MaxValue, 1'b1, 1'b0}},
         '{Zero,     Zero,     CheckTyped, '{MaxValue, 1'b0, 1'b1}},
         '{One,      Zero,     CheckTyped, '{MinValue, 1'b0, 1'b1}},
         '{MaxValue, Zero,     CheckTyped, '{MinValue, 1'b0, 1'b1}},
         '{NegOne,   Zero,     CheckTyped, '{MaxValue, 1'b0, 1'b1}},
         '{MinValue, Zero,     CheckTyped, '{MaxValue, 1'b0, 1'b1}},
         // Extremes of both operands.
         '{MinValue, One,      CheckTyped, '{MinValue, 1'b0, 1'b0}},
         '{MaxValue, One,      CheckTyped, '{MaxValue, 1'b0, 1'b0}},
         '{MaxValue, NegOne,   CheckTyped, '{MinValue + One, 1'b0, 1'b0}},
         '{MinValue, MinValue, CheckTyped, '{One, 1'b0, 1'b0}},
         '{MaxValue, MaxValue, CheckTyped, '{One, 1'b0, 1'b0}},
         '{MaxValue, MinValue, CheckTyped, '{Zero, 1'b0, 1'b0}},
         '{MinValue, MaxValue, CheckTyped, '{NegOne, 1'b0, 1'b0}},
         // A zero dividend keeps a zero quotient whatever the divisor sign.
         '{Zero,     NegOne,   CheckTyped, '{Zero, 1'b0, 1'b0}},
         '{Zero,     MinValue, CheckTyped, '{Zero, 1'b0, 1'b0}},
         // Truncation toward zero in all four sign combinations.
         '{MinValue, sid_pkg::word_type'(2), CheckModel, NoResult},
         '{sid_pkg::word_type'(7),  sid_pkg::word_type'(2),  CheckModel, NoResult},
         '{sid_pkg::word_type'(-7), sid_pkg::word_type'(2),  CheckModel, NoResult},
         '{sid_pkg::word_type'(7),  sid_pkg::word_type'(-2), CheckModel, NoResult},
         '{sid_pkg::word_type'(-7), sid_pkg::word_type'(-2), CheckModel, NoResult},
         '{One,           MaxValue,               CheckModel, NoResult},
         '{32'h5555_5555, sid_pkg::word_type'(3), CheckModel, NoResult},
         '{32'hAAAA_AAAA, 32'h0001_0001,          CheckModel, NoResult}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (directed_rows[i]) begin
         send_division(directed_rows[i].dividend, directed_rows[i].divisor,
                       directed_rows[i].check, directed_rows[i].want, pick_gap(i < 8));
      end
      drain_pipeline();

      // Random transactions in stretches with and without idle cycles.
      quiet = 1'b0;
      for (int n = 0; n < RandomItems; n++) begin
         if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 49) == 0) begin
            a = MinValue;
            b = NegOne;
         end else begin
            a = pick_operand();
            b = pick_operand();
         end
         send_division(a, b, CheckModel, NoResult, pick_gap(quiet));
         if (n % DrainInterval == DrainInterval - 1) drain_pipeline();
      end

      drain_pipeline();
      repeat (sid_pkg::Latency + 4) @(posedge clock);
      if (expected_quotients.size() != 0) begin
         $error("%0d expected results never arrived", expected_quotients.size());
         error_count++;
      end

      $display("Sent %0d divisions and checked %0d results, %0d by zero, %0d saturated.",
               sent_count, checked_count, zero_count, sat_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
